// File: design/pced_pkg.sv
// ----------------------------------------------------------------------------
// pced_pkg
// shared types and constants of the prefix compressed entry decoder
// ----------------------------------------------------------------------------
package pced_pkg;

  localparam int unsigned       MAX_KEY_DEF   = 1024;
  localparam longint unsigned   MAX_VALUE_DEF = 65535;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_CORRUPT = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] prefix_len;
    logic [10:0] suffix_len;
    logic [15:0] val_len;
    logic [15:0] byte_pos;
    logic [7:0]  out_byte;
  } res_t;

  // one request: a full first result and an optional done or corrupt result
  typedef struct packed {
    logic       two;
    logic [2:0] second_kind;
    res_t       first;
  } bundle_t;

endpackage

// File: design/pced_front.sv
// ----------------------------------------------------------------------------
// pced_front
// varint and entry decode state; turns each byte into at most one request
// ----------------------------------------------------------------------------
module pced_front #(
  parameter int unsigned     MAX_KEY   = pced_pkg::MAX_KEY_DEF,
  parameter longint unsigned MAX_VALUE = pced_pkg::MAX_VALUE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output pced_pkg::bundle_t q_wdata
);
  import pced_pkg::*;

  localparam int KW  = $clog2(MAX_KEY + 1);
  localparam int VLW = $clog2(MAX_VALUE + 1);
  localparam int CW  = (KW > VLW) ? KW : VLW;

  localparam logic [2:0] PH_SHARED   = 3'd0;
  localparam logic [2:0] PH_UNSHARED = 3'd1;
  localparam logic [2:0] PH_VALUE    = 3'd2;
  localparam logic [2:0] PH_KEY      = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;

  localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

  logic [2:0]     phase_r, phase_nxt;
  logic [31:0]    accum_r, accum_nxt;
  logic [2:0]     count_r, count_nxt;
  logic [KW-1:0]  key_length_r, key_length_nxt;
  logic [KW-1:0]  held_shared_r, held_shared_nxt;
  logic [KW-1:0]  held_unshared_r, held_unshared_nxt;
  logic [VLW-1:0] held_value_len_r, held_value_len_nxt;
  logic [CW-1:0]  bytes_done_r, bytes_done_nxt;
  logic           error_seen_r, error_seen_nxt;

  logic        accept;
  logic        bad;
  logic        done;
  logic        have0;
  logic        new_blk;
  logic [31:0] shifted;
  logic [31:0] v;
  logic [2:0]  cnt_inc;
  logic [CW-1:0] inc;
  bundle_t     bnd;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && have0;
  assign q_wdata   = bnd;

  always_comb begin
    case (count_r)
      3'd0:    shifted = 32'(in_tdata[6:0]);
      3'd1:    shifted = 32'(in_tdata[6:0]) << 7;
      3'd2:    shifted = 32'(in_tdata[6:0]) << 14;
      3'd3:    shifted = 32'(in_tdata[6:0]) << 21;
      3'd4:    shifted = 32'(in_tdata[6:0]) << 28;
      default: shifted = '0;
    endcase
  end

  assign v       = accum_r | shifted;
  assign cnt_inc = count_r + 3'd1;
  assign inc     = bytes_done_r + CW'(1);

  always_comb begin
    phase_nxt          = phase_r;
    accum_nxt          = accum_r;
    count_nxt          = count_r;
    key_length_nxt     = key_length_r;
    held_shared_nxt    = held_shared_r;
    held_unshared_nxt  = held_unshared_r;
    held_value_len_nxt = held_value_len_r;
    bytes_done_nxt     = bytes_done_r;
    error_seen_nxt     = error_seen_r;
    bad                = 1'b0;
    done               = 1'b0;
    have0              = 1'b0;
    new_blk            = 1'b0;
    bnd                = '0;
    bnd.second_kind    = KIND_DONE;

    if (error_seen_r) begin
      new_blk = in_tlast;
    end else begin
      case (phase_r)
        PH_SHARED, PH_UNSHARED, PH_VALUE: begin
          if (in_tdata[7]) begin
            accum_nxt = v;
            count_nxt = cnt_inc;
            if (cnt_inc >= VARINT_MAX_BYTES) begin
              bad = 1'b1;
            end
          end else begin
            accum_nxt = '0;
            count_nxt = '0;
            if (phase_r == PH_SHARED) begin
              if (v > 32'(key_length_r)) begin
                bad = 1'b1;
              end else begin
                held_shared_nxt = KW'(v);
                phase_nxt       = PH_UNSHARED;
              end
            end else if (phase_r == PH_UNSHARED) begin
              if (33'(held_shared_r) + 33'(v) > 33'(MAX_KEY)) begin
                bad = 1'b1;
              end else begin
                held_unshared_nxt = KW'(v);
                phase_nxt         = PH_VALUE;
              end
            end else begin
              if (33'(v) > 33'(MAX_VALUE)) begin
                bad = 1'b1;
              end else begin
                held_value_len_nxt       = VLW'(v);
                key_length_nxt           = held_shared_r + held_unshared_r;
                have0                    = 1'b1;
                bnd.first.kind           = KIND_HEADER;
                bnd.first.prefix_len     = 11'(held_shared_r);
                bnd.first.suffix_len     = 11'(held_unshared_r);
                bnd.first.val_len        = 16'(v);
                bytes_done_nxt           = '0;
                if (held_unshared_r != '0) begin
                  phase_nxt = PH_KEY;
                end else if (v != '0) begin
                  phase_nxt = PH_DATA;
                end else begin
                  done = 1'b1;
                end
              end
            end
          end
        end
        PH_KEY: begin
          have0              = 1'b1;
          bnd.first.kind     = KIND_KEY;
          bnd.first.byte_pos = 16'(held_shared_r) + 16'(bytes_done_r);
          bnd.first.out_byte = in_tdata;
          bytes_done_nxt     = inc;
          if (inc >= CW'(held_unshared_r)) begin
            bytes_done_nxt = '0;
            if (held_value_len_r != '0) begin
              phase_nxt = PH_DATA;
            end else begin
              done = 1'b1;
            end
          end
        end
        default: begin
          have0              = 1'b1;
          bnd.first.kind     = KIND_VALUE;
          bnd.first.byte_pos = 16'(bytes_done_r);
          bnd.first.out_byte = in_tdata;
          bytes_done_nxt     = inc;
          if (inc >= CW'(held_value_len_r)) begin
            done = 1'b1;
          end
        end
      endcase

      if (done) begin
        bnd.two         = 1'b1;
        bnd.second_kind = KIND_DONE;
        phase_nxt       = PH_SHARED;
        bytes_done_nxt  = '0;
      end

      // truncated entry
      if (!bad && in_tlast && (phase_nxt != PH_SHARED || count_nxt != '0)) begin
        bad = 1'b1;
      end

      if (bad) begin
        if (have0) begin
          bnd.two         = 1'b1;
          bnd.second_kind = KIND_CORRUPT;
        end else begin
          have0          = 1'b1;
          bnd.first.kind = KIND_CORRUPT;
        end
        if (in_tlast) begin
          new_blk = 1'b1;
        end else begin
          error_seen_nxt = 1'b1;
        end
      end else if (in_tlast) begin
        new_blk = 1'b1;
      end
    end

    if (new_blk) begin
      phase_nxt          = PH_SHARED;
      accum_nxt          = '0;
      count_nxt          = '0;
      key_length_nxt     = '0;
      held_shared_nxt    = '0;
      held_unshared_nxt  = '0;
      held_value_len_nxt = '0;
      bytes_done_nxt     = '0;
      error_seen_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SHARED;
      accum_r          <= '0;
      count_r          <= '0;
      key_length_r     <= '0;
      held_shared_r    <= '0;
      held_unshared_r  <= '0;
      held_value_len_r <= '0;
      bytes_done_r     <= '0;
      error_seen_r     <= 1'b0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      accum_r          <= accum_nxt;
      count_r          <= count_nxt;
      key_length_r     <= key_length_nxt;
      held_shared_r    <= held_shared_nxt;
      held_unshared_r  <= held_unshared_nxt;
      held_value_len_r <= held_value_len_nxt;
      bytes_done_r     <= bytes_done_nxt;
      error_seen_r     <= error_seen_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    error_seen_r |-> !q_push)
    else $error("request pushed while dropping a corrupt block");

  a_key_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY) |-> (bytes_done_r < CW'(held_unshared_r)))
    else $error("key byte index past unshared length");

  a_key_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    33'(key_length_r) <= 33'(MAX_KEY))
    else $error("key length above limit");

  a_last_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (phase_r == PH_SHARED && key_length_r == '0 &&
                              !error_seen_r && count_r == '0))
    else $error("last byte did not start a new block");
`endif

endmodule

// File: design/pced_queue.sv
// ----------------------------------------------------------------------------
// pced_queue
// short request queue between the decode front and the output back
// ----------------------------------------------------------------------------
module pced_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pced_pkg::bundle_t wdata,
  output logic              full,
  input  logic              pop,
  output pced_pkg::bundle_t head,
  output logic              empty
);
  import pced_pkg::*;

  bundle_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   fill_r, fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (fill_r == (QAW + 1)'(QDEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: design/pced_back.sv
// ----------------------------------------------------------------------------
// pced_back
// output side: sends the one or two results of each request in order
// ----------------------------------------------------------------------------
module pced_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pced_pkg::bundle_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);
  import pced_pkg::*;

  logic sel_r, sel_nxt;
  logic out_acc;
  res_t cur;

  assign out_tvalid = !empty;
  assign out_acc    = out_tvalid && out_tready;
  assign pop        = out_acc && (sel_r || !head.two);

  always_comb begin
    if (sel_r) begin
      cur      = '0;
      cur.kind = head.second_kind;
    end else begin
      cur = head.first;
    end
  end

  assign out_tuser = cur.kind;
  assign out_tdata = {2'b00, cur.out_byte, cur.byte_pos, cur.val_len,
                      cur.suffix_len, cur.prefix_len};
  assign out_tlast = sel_r || !head.two;

  always_comb begin
    sel_nxt = sel_r;
    if (pop) begin
      sel_nxt = 1'b0;
    end else if (out_acc) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// File: design/prefix_compressed_entry_decoder.sv
// ----------------------------------------------------------------------------
// prefix_compressed_entry_decoder
// decodes the entry region of a sorted-table block into header, key byte,
// value byte, entry done and corrupt results
//
//   channel  dir  tdata                              tuser  tlast
//   in_      in   data_byte[7:0]                     -      last_byte
//   out_     out  prefix_len, suffix_len,            kind   run_last
//                 val_len, byte_pos, out_byte
//
// one byte is accepted per cycle while the four-entry request queue has room
// a byte that causes two results sends them as two separate output transfers,
// so the sustained rate is set by the output port at one result per cycle
// while out_tready is high; in_tready drops only when the queue is full;
// output stalls never reach the decode state directly
// synchronous reset clears the decode state and queue, giving an empty key
// ----------------------------------------------------------------------------
module prefix_compressed_entry_decoder #(
  parameter int unsigned     MAX_KEY   = pced_pkg::MAX_KEY_DEF,
  parameter longint unsigned MAX_VALUE = pced_pkg::MAX_VALUE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // prefix_len, suffix_len, val_len, byte_pos, out_byte
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast
);
  import pced_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_head;

  pced_front #(
    .MAX_KEY   (MAX_KEY),
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pced_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  pced_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
